### rtl/rfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_pkg: shared types and constants for the RTCM3 frame finder
//
// Item types for both channels, framing constants, event codes and the
// one-byte CRC-24Q update.
// ----------------------------------------------------------------------------
package rfs_pkg;

  // Framing constants.
  localparam logic [7:0]  PREAMBLE           = 8'hD3;
  localparam logic [7:0]  RESERVED_MASK      = 8'hFC;
  localparam logic [7:0]  LENGTH_HIGH_MASK   = 8'h03;
  localparam logic [10:0] FRAME_OVERHEAD     = 11'd6;
  localparam logic [10:0] FRAME_BUFFER_BYTES = 11'd1029;
  localparam logic [10:0] MAX_FRAME_RESET    = 11'd1029;
  localparam logic [23:0] CRC24Q_POLY        = 24'h864CFB;

  // End-of-frame event codes.
  localparam logic [1:0] EVENT_NONE     = 2'd0;
  localparam logic [1:0] EVENT_GOOD_CRC = 2'd1;
  localparam logic [1:0] EVENT_BAD_CRC  = 2'd2;
  localparam logic [1:0] EVENT_REJECT   = 2'd3;

  // Positions that the parser treats specially.
  localparam logic [10:0] POS_HUNT   = 11'd0;
  localparam logic [10:0] POS_HEADER = 11'd1;
  localparam logic [10:0] POS_LENGTH = 11'd2;
  localparam logic [10:0] POS_BODY   = 11'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush_parser;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        byte_in_frame;
    logic [10:0] frame_position;
    logic [1:0]  frame_event;
    logic [10:0] frame_length;
  } out_item_t;

  // Result handed from the parser to the output buffer.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // CRC-24Q over one byte, MSB first, no reflection.
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_in,
                                              input logic [7:0]  data);
    logic [23:0] crc;
    logic        top;
    crc = crc_in ^ {data, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      top = crc[23];
      crc = {crc[22:0], 1'b0};
      if (top) begin
        crc = crc ^ CRC24Q_POLY;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

### rtl/rfs_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_parser: frame state and CRC for one byte per cycle while accept is high
//
// Holds the parse state and the maximum frame length register. Every
// accepted item updates the state and yields one result in the same cycle.
// ----------------------------------------------------------------------------
module rfs_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire rfs_pkg::in_item_t in_item,
  input  wire logic              cfg_write,
  input  wire logic [10:0]       cfg_data,
  output rfs_pkg::result_t       result
);
  import rfs_pkg::*;

  logic [10:0] max_frame_bytes;
  logic [10:0] bytes_held, bytes_held_next;
  logic [10:0] expected_total, expected_total_next;
  logic [1:0]  length_high_bits, length_high_bits_next;
  logic [23:0] running_crc, running_crc_next;

  logic [23:0] crc_step;
  logic [23:0] crc_first;
  logic [10:0] total;
  logic [10:0] held_inc;
  logic [7:0]  b;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_write) begin
      max_frame_bytes <= cfg_data;
    end
  end

  assign b         = in_item.data_byte;
  assign crc_step  = crc24q_byte(running_crc, b);
  assign crc_first = crc24q_byte(24'h000000, b);
  assign total     = {1'b0, length_high_bits, b} + FRAME_OVERHEAD;
  assign held_inc  = bytes_held + 11'd1;

  // Next state and result for the current byte.
  always_comb begin
    bytes_held_next       = bytes_held;
    expected_total_next   = expected_total;
    length_high_bits_next = length_high_bits;
    running_crc_next      = running_crc;
    result.valid               = accept;
    result.item.echo_byte      = b;
    result.item.byte_in_frame  = 1'b0;
    result.item.frame_position = POS_HUNT;
    result.item.frame_event    = EVENT_NONE;
    result.item.frame_length   = 11'd0;

    if (in_item.flush_parser) begin
      bytes_held_next       = POS_HUNT;
      expected_total_next   = 11'd0;
      length_high_bits_next = 2'd0;
      running_crc_next      = 24'h000000;
    end else if (bytes_held == POS_HUNT) begin
      if (b == PREAMBLE) begin
        running_crc_next          = crc_first;
        bytes_held_next           = POS_HEADER;
        result.item.byte_in_frame = 1'b1;
      end
    end else if (bytes_held == POS_HEADER) begin
      if ((b & RESERVED_MASK) != 8'h00) begin
        // Reserved bits set: reject, but a preamble byte starts over.
        result.item.frame_event = EVENT_REJECT;
        bytes_held_next         = POS_HUNT;
        expected_total_next     = 11'd0;
        length_high_bits_next   = 2'd0;
        running_crc_next        = 24'h000000;
        if (b == PREAMBLE) begin
          running_crc_next          = crc_first;
          bytes_held_next           = POS_HEADER;
          result.item.byte_in_frame = 1'b1;
        end
      end else begin
        length_high_bits_next      = b[1:0] & LENGTH_HIGH_MASK[1:0];
        running_crc_next           = crc_step;
        bytes_held_next            = POS_LENGTH;
        result.item.byte_in_frame  = 1'b1;
        result.item.frame_position = POS_HEADER;
      end
    end else if (bytes_held == POS_LENGTH) begin
      if (total > max_frame_bytes || total > FRAME_BUFFER_BYTES) begin
        result.item.frame_event = EVENT_REJECT;
        bytes_held_next         = POS_HUNT;
        expected_total_next     = 11'd0;
        length_high_bits_next   = 2'd0;
        running_crc_next        = 24'h000000;
      end else begin
        expected_total_next        = total;
        running_crc_next           = crc_step;
        bytes_held_next            = POS_BODY;
        result.item.byte_in_frame  = 1'b1;
        result.item.frame_position = POS_LENGTH;
      end
    end else begin
      // Payload and CRC bytes.
      running_crc_next           = crc_step;
      bytes_held_next            = held_inc;
      result.item.byte_in_frame  = 1'b1;
      result.item.frame_position = bytes_held;
      if (held_inc >= expected_total) begin
        result.item.frame_event  = (crc_step == 24'h000000) ? EVENT_GOOD_CRC
                                                            : EVENT_BAD_CRC;
        result.item.frame_length = held_inc;
        bytes_held_next          = POS_HUNT;
        expected_total_next      = 11'd0;
        length_high_bits_next    = 2'd0;
        running_crc_next         = 24'h000000;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held       <= POS_HUNT;
      expected_total   <= 11'd0;
      length_high_bits <= 2'd0;
      running_crc      <= 24'h000000;
    end else if (accept) begin
      bytes_held       <= bytes_held_next;
      expected_total   <= expected_total_next;
      length_high_bits <= length_high_bits_next;
      running_crc      <= running_crc_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rfs_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_out_buf: output register with skid stage
//
// Registers each result and parks one more item while the output stalls,
// so the input side keeps flowing until both places are full.
// ----------------------------------------------------------------------------
module rfs_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rfs_pkg::result_t  result,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rfs_pkg::out_item_t     out_item
);
  import rfs_pkg::*;

  logic      skid_valid;
  out_item_t skid_item;
  logic      main_free;

  assign main_free = !out_valid || !out_stall;
  assign full      = skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      out_valid  <= skid_valid || result.valid;
      skid_valid <= 1'b0;
    end else if (result.valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers; the skid item always goes out first.
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (result.valid) begin
        out_item <= result.item;
      end
    end else if (result.valid) begin
      skid_item <= result.item;
    end
  end

endmodule
`default_nettype wire

### rtl/rtcm3_frame_sync_crc24q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcm3_frame_sync_crc24q: RTCM3 frame finder with CRC-24Q check
//
// Takes one receiver byte per item and reports frame position and events.
// ----------------------------------------------------------------------------
// The block accepts one byte every clock cycle while in_stall is low and
// returns exactly one result item per input item. The frame state and the
// one-byte CRC-24Q update sit between the input handshake and the output
// register. A two-place output buffer lets the input keep going for one
// item while the output stalls; in_stall rises only when both places hold
// items. A flush item returns the parser to preamble hunting. The register
// max_frame_bytes resets to 1029 and is written via cfg_write and cfg_data;
// the user must write it only while the block is idle; nothing enforces it.
module rtcm3_frame_sync_crc24q (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rfs_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rfs_pkg::out_item_t      out_item,
  input  wire logic               cfg_write,
  input  wire logic [10:0]        cfg_data
);
  import rfs_pkg::*;

  logic    accept;
  result_t result;
  logic    buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // Frame parser and CRC.
  rfs_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // Output register and skid stage.
  rfs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RTCM3 frame finder
//
// Drives raw receiver bytes and flush items, with random gaps on the input
// and random stalls on the output. A frame tracker follows the framing rules
// and the CRC-24Q in step with each accepted byte and checks every result
// field by field. The run starts with short directed sequences, then walks
// through several max_frame_bytes settings with random well-formed,
// corrupted, rejected and truncated frames mixed with noise.
// ----------------------------------------------------------------------------
module testbench;
  import rfs_pkg::*;

  // Follows the framing state byte by byte and holds the results still due.
  class rtcm_frame_tracker;
    logic [10:0] max_total;
    logic [10:0] held;
    logic [10:0] frame_total;
    logic [1:0]  len_hi;
    logic [23:0] crc;
    out_item_t   expected_results[$];
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned frames_good;
    int unsigned frames_bad;
    int unsigned header_rejects;
    int unsigned flushes;

    function new();
      max_total = MAX_FRAME_RESET;
      restart();
    endfunction

    // CRC-24Q over one byte, MSB first, zero initial value.
    static function logic [23:0] crc_update(logic [23:0] crc_in, logic [7:0] data);
      logic [24:0] r;
      r = {1'b0, crc_in ^ {data, 16'h0000}};
      for (int i = 0; i < 8; i++) begin
        r = r << 1;
        if (r[24]) begin
          r = r ^ {1'b1, CRC24Q_POLY};
        end
      end
      return r[23:0];
    endfunction

    function void restart();
      held        = '0;
      frame_total = '0;
      len_hi      = '0;
      crc         = '0;
    endfunction

    // A preamble opens a new candidate at position 0.
    function void start_frame(inout out_item_t r);
      crc             = crc_update('0, PREAMBLE);
      held            = 11'd1;
      r.byte_in_frame = 1'b1;
    endfunction

    function void report_mismatch(string msg);
      if (mismatch_count < 40) begin
        $display("MISMATCH at result %0d: %s", results_checked, msg);
      end
      mismatch_count++;
    endfunction

    // Works out the result of one accepted input item.
    function void note_byte(in_item_t it);
      out_item_t   r;
      logic [7:0]  b;
      logic [10:0] total;
      b           = it.data_byte;
      r           = '0;
      r.echo_byte = b;
      if (it.flush_parser) begin
        restart();
        flushes++;
      end else if (held == 0) begin
        if (b == PREAMBLE) begin
          start_frame(r);
        end
      end else if (held == 1) begin
        if ((b & RESERVED_MASK) != 0) begin
          r.frame_event = EVENT_REJECT;
          restart();
          if (b == PREAMBLE) begin
            start_frame(r);
          end
        end else begin
          len_hi           = b[1:0];
          crc              = crc_update(crc, b);
          held             = 11'd2;
          r.byte_in_frame  = 1'b1;
          r.frame_position = POS_HEADER;
        end
      end else if (held == 2) begin
        total = {1'b0, len_hi, b} + FRAME_OVERHEAD;
        if (total > max_total || total > FRAME_BUFFER_BYTES) begin
          r.frame_event = EVENT_REJECT;
          restart();
        end else begin
          frame_total      = total;
          crc              = crc_update(crc, b);
          held             = 11'd3;
          r.byte_in_frame  = 1'b1;
          r.frame_position = POS_LENGTH;
        end
      end else begin
        crc              = crc_update(crc, b);
        r.byte_in_frame  = 1'b1;
        r.frame_position = held;
        held             = held + 11'd1;
        if (held >= frame_total) begin
          r.frame_event  = (crc == 0) ? EVENT_GOOD_CRC : EVENT_BAD_CRC;
          r.frame_length = held;
          restart();
        end
      end
      if (r.frame_event == EVENT_GOOD_CRC) frames_good++;
      if (r.frame_event == EVENT_BAD_CRC) frames_bad++;
      if (r.frame_event == EVENT_REJECT) header_rejects++;
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [10:0] got, logic [10:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no byte waiting for one");
      end else begin
        want = expected_results.pop_front();
        check_field("echo_byte", 11'(got.echo_byte), 11'(want.echo_byte));
        check_field("byte_in_frame", 11'(got.byte_in_frame), 11'(want.byte_in_frame));
        check_field("frame_position", got.frame_position, want.frame_position);
        check_field("frame_event", 11'(got.frame_event), 11'(want.frame_event));
        check_field("frame_length", got.frame_length, want.frame_length);
      end
      results_checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_write = 1'b0;
  logic [10:0] cfg_data = '0;

  rtcm_frame_tracker tracker = new();

  logic [10:0] cur_max = MAX_FRAME_RESET;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned sent_count = 0;
  int unsigned settings_run = 0;

  // Settings per phase: limit on frame size, output stall and input gap rates.
  int unsigned phase_max[7]   = '{1029, 6, 2047, 40, 5, 300, 1029};
  int unsigned phase_stall[7] = '{25, 0, 40, 60, 10, 30, 0};
  int unsigned phase_gap[7]   = '{25, 0, 10, 50, 40, 15, 0};

  rtcm3_frame_sync_crc24q u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Output stalls: mostly short bursts, now and then a long one.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      stall_left = ($urandom_range(19, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Both handshakes are sampled at the edge where they complete.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tracker.note_byte(in_item);
      end
      if (out_valid && !out_stall) begin
        tracker.check_result(out_item);
      end
    end
  end

  // Presents one item and holds it until accepted, then maybe leaves a gap.
  task automatic send_byte(input logic [7:0] data, input logic flush);
    int unsigned gap;
    in_item  <= {data, flush};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if ($urandom_range(99, 0) < gap_pct) begin
      gap = ($urandom_range(15, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a complete frame with its CRC, optionally with one byte damaged.
  task automatic send_frame(input int unsigned payload_len, input bit corrupt);
    logic [9:0]  plen;
    logic [7:0]  frame_bytes[$];
    logic [23:0] crc;
    int unsigned pos;
    plen = payload_len[9:0];
    frame_bytes.push_back(PREAMBLE);
    frame_bytes.push_back({6'b000000, plen[9:8]});
    frame_bytes.push_back(plen[7:0]);
    repeat (plen) frame_bytes.push_back(8'($urandom));
    crc = '0;
    foreach (frame_bytes[k]) crc = tracker.crc_update(crc, frame_bytes[k]);
    frame_bytes.push_back(crc[23:16]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    if (corrupt) begin
      pos = $urandom_range(frame_bytes.size() - 1, 3);
      frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(255, 1));
    end
    foreach (frame_bytes[k]) send_byte(frame_bytes[k], 1'b0);
  endtask

  // Short payloads, mostly sized to fit the current limit.
  function automatic int unsigned pick_payload_len();
    int unsigned n;
    n = $urandom_range(20, 0);
    if (cur_max >= FRAME_OVERHEAD && $urandom_range(99, 0) < 85 && n + 6 > cur_max) begin
      n = cur_max - 6;
    end
    return n;
  endfunction

  // One random piece of stream: frames, broken frames, noise or flushes.
  task automatic send_random_piece();
    int unsigned pick;
    int unsigned n;
    logic [9:0]  plen;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      send_frame(pick_payload_len(), 1'b0);
    end else if (pick < 65) begin
      send_frame(pick_payload_len(), 1'b1);
    end else if (pick < 72) begin
      // Reserved bits set in the second byte, sometimes a fresh preamble.
      send_byte(PREAMBLE, 1'b0);
      send_byte(($urandom_range(3, 0) == 0) ? PREAMBLE : 8'($urandom_range(255, 4)), 1'b0);
    end else if (pick < 79) begin
      // Total length right at the limit or one above it.
      if (cur_max >= FRAME_BUFFER_BYTES || cur_max < FRAME_OVERHEAD) begin
        send_frame(pick_payload_len(), 1'b0);
      end else begin
        send_frame(cur_max - 6 + $urandom_range(1, 0), 1'b0);
      end
    end else if (pick < 86) begin
      // Frame cut short by a flush.
      plen = 10'($urandom_range(20, 0));
      send_byte(PREAMBLE, 1'b0);
      send_byte({6'b000000, plen[9:8]}, 1'b0);
      send_byte(plen[7:0], 1'b0);
      repeat ($urandom_range(plen + 2, 0)) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end else if (pick < 94) begin
      n = $urandom_range(6, 1);
      repeat (n) send_byte(8'($urandom), 1'b0);
      if ($urandom_range(1, 0) == 0) begin
        send_byte(8'($urandom), 1'b1);
      end
    end else begin
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  // Waits until every expected result has come out.
  // The first edge lets the last accepted byte reach the tracker.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_total(input logic [10:0] value);
    drain();
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.max_total = value;
    cur_max = value;
    settings_run++;
  endtask

  initial begin
    int unsigned phase_start;
    do @(posedge clk); while (rst);

    // Directed sequences at the reset limit.
    send_byte(8'h00, 1'b0);            // noise while hunting
    send_byte(8'hFF, 1'b0);
    send_byte(PREAMBLE, 1'b0);         // reserved bits set
    send_byte(RESERVED_MASK, 1'b0);
    send_byte(PREAMBLE, 1'b0);         // second preamble rejects, then restarts
    send_frame(0, 1'b0);
    send_byte(PREAMBLE, 1'b0);         // largest length, then a flush
    send_byte(LENGTH_HIGH_MASK, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_frame(0, 1'b1);               // shortest frame with a bad CRC

    // Length above the limit is rejected on the third byte.
    write_max_total(11'd6);
    send_byte(PREAMBLE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);

    // Random phases over several limits.
    for (int p = 0; p < 7; p++) begin
      write_max_total(11'(phase_max[p]));
      stall_pct = phase_stall[p];
      gap_pct   = phase_gap[p];
      // The longest legal frame, once, under a limit above the buffer size.
      if (p == 2) begin
        send_frame(1023, 1'b0);
      end
      phase_start = sent_count;
      while (sent_count < phase_start + 75) send_random_piece();
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.expected_results.size() != 0) begin
      tracker.report_mismatch("results still expected at the end of the run");
    end
    $display("Sent %0d items over %0d max_frame_bytes settings; %0d results checked.",
             sent_count, settings_run, tracker.results_checked);
    $display("Frames seen: %0d good CRC, %0d bad CRC, %0d header rejects, %0d flushes.",
             tracker.frames_good, tracker.frames_bad, tracker.header_rejects,
             tracker.flushes);
    if (tracker.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guards against a hang.
  initial begin
    #40_000_000;
    $display("Timeout with %0d results still expected.", tracker.expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
rtl/rfs_pkg.sv
rtl/rfs_parser.sv
rtl/rfs_out_buf.sv
rtl/rtcm3_frame_sync_crc24q.sv
bench/testbench.sv
